// ----- hdl/nearest_centroid_radius_classifier_top_macros.svh -----
// Assertion macros for the nearest centroid classifier.
// Used by the top level only; no other dependency.
`ifndef NEAREST_CENTROID_RADIUS_CLASSIFIER_TOP_MACROS_SVH
`define NEAREST_CENTROID_RADIUS_CLASSIFIER_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define NCRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication outside reset.
`define NCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- hdl/ncrc_pkg.sv -----
// Shared types and constants for the nearest centroid classifier.
// No dependencies.
`default_nettype none
package ncrc_pkg;
  typedef enum logic [1:0] {
    CMD_CENTRE  = 2'd0,
    CMD_RADIUS  = 2'd1,
    CMD_EXAMPLE = 2'd2,
    CMD_RSVD    = 2'd3
  } cmd_t;

  localparam int COORD_W = 16;
  localparam int RADIUS_W = 17;
  localparam int LABEL_W = 8;
  localparam int SUM_W = 40;
  localparam int ROOT_W = 20;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [1:0] REG_CLUSTER_COUNT = 2'd0;
  localparam logic [1:0] REG_DIMS_IN_USE   = 2'd1;
  localparam logic [1:0] REG_UNKNOWN_LABEL = 2'd2;
endpackage
`default_nettype wire

// ----- hdl/ncrc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module ncrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/ncrc_isqrt.sv -----
// Iterative floor square root, one result bit per radicand bit pair; start restarts it.
// Depends on ncrc_pkg.
`default_nettype none
module ncrc_isqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [ncrc_pkg::SUM_W-1:0]  radicand,
  output logic                             done,
  output logic      [ncrc_pkg::ROOT_W-1:0] root
);
  import ncrc_pkg::*;

  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  x;
  logic [ROOT_W-1:0] count;
  logic [4:0]        step;
  logic              busy;
  logic [ROOT_W+1:0] trial;
  logic [ROOT_W+1:0] rem_hi;

  // restoring digit recurrence: bring in two radicand bits per step
  always_comb begin
    rem_hi = {rem[ROOT_W-1:0], x[SUM_W-1 -: 2]};
    trial  = {count, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        x     <= radicand;
        rem   <= '0;
        count <= '0;
        step  <= '0;
      end else if (busy) begin
        x <= {x[SUM_W-3:0], 2'b00};
        if (rem_hi >= trial) begin
          rem   <= SUM_W'(rem_hi - trial);
          count <= {count[ROOT_W-2:0], 1'b1};
        end else begin
          rem   <= SUM_W'(rem_hi);
          count <= {count[ROOT_W-2:0], 1'b0};
        end
        step <= step + 5'd1;
        if (step == 5'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = count;
endmodule
`default_nettype wire

// ----- hdl/nearest_centroid_radius_classifier_top.sv -----
// Nearest centroid classifier with per-cluster acceptance radius. Load items
// (command 0 centre coordinate, 1 radius and label) write the cluster tables
// and are taken back to back, one per cycle, while no search runs. Example
// coordinates (command 2) are buffered; the one at index dims_in_use-1 starts
// a search that streams every centre coordinate in use out of the centre RAM,
// one coordinate per cycle. The sums then pass the distance pipeline, the
// radius read and square, the 20-step square root and the output register.
// Ties go to the later cluster; the squared sum saturates at 2^40-1. The
// result is held in an output register until taken; a search that ends while
// the previous result still waits holds there. A new item is accepted once
// the search has handed its result to that register.
// Registers (APB, 32-bit, byte address 4*i): 0 cluster_count, 1 dims_in_use,
// 2 unknown_label. Depends on ncrc_pkg, ncrc_ram, ncrc_isqrt and the macro
// header. No clearing pass: all tables are undefined until written.
`default_nettype none
`include "nearest_centroid_radius_classifier_top_macros.svh"
module nearest_centroid_radius_classifier_top #(
  parameter int MAX_CLUSTERS = 128,
  parameter int MAX_DIMS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  command,
  input  wire logic [6:0]  cluster_index,
  input  wire logic [4:0]  dim_index,
  input  wire logic signed [15:0] coordinate,
  input  wire logic [16:0] radius_in,
  input  wire logic [7:0]  label_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       label,
  output logic             known,
  output logic [6:0]       nearest_cluster,
  output logic [19:0]      distance,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ncrc_pkg::*;

  localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CDEPTH = (MAX_CLUSTERS > 1) ? MAX_CLUSTERS : 2;
  localparam int DDEPTH = (MAX_DIMS > 1) ? MAX_DIMS : 2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_RADIUS, S_COVER, S_ROOT, S_OUT
  } state_t;

  // configuration registers
  logic [7:0] cluster_count;
  logic [5:0] dims_in_use;
  logic [7:0] unknown_label;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= 8'd1;
      dims_in_use   <= 6'd1;
      unknown_label <= 8'd0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3:2] == REG_CLUSTER_COUNT && paddr[1:0] == 2'd0)
        cluster_count <= pwdata[7:0];
      else if (paddr[3:2] == REG_DIMS_IN_USE && paddr[1:0] == 2'd0)
        dims_in_use <= pwdata[5:0];
      else if (paddr[3:2] == REG_UNKNOWN_LABEL && paddr[1:0] == 2'd0)
        unknown_label <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == {REG_CLUSTER_COUNT, 2'b00}) prdata[7:0] = cluster_count;
    else if (paddr == {REG_DIMS_IN_USE, 2'b00}) prdata[5:0] = dims_in_use;
    else if (paddr == {REG_UNKNOWN_LABEL, 2'b00}) prdata[7:0] = unknown_label;
  end

  // clamped register values: index of the last cluster and last dimension
  logic [CW-1:0] last_k;
  logic [DW-1:0] last_d;
  always_comb begin
    if (cluster_count == 8'd0) last_k = '0;
    else if (32'(cluster_count) > MAX_CLUSTERS) last_k = CW'(MAX_CLUSTERS - 1);
    else last_k = CW'(cluster_count - 8'd1);
    if (dims_in_use == 6'd0) last_d = '0;
    else if (32'(dims_in_use) > MAX_DIMS) last_d = DW'(MAX_DIMS - 1);
    else last_d = DW'(dims_in_use - 6'd1);
  end

  state_t state;
  logic   accept;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  logic ci_ok, di_ok;
  assign ci_ok = 32'(cluster_index) < MAX_CLUSTERS;
  assign di_ok = 32'(dim_index) < MAX_DIMS;

  // scan counters
  logic [CW-1:0] k;
  logic [DW-1:0] d;

  // centre RAM: write on load, read during scan
  logic              cen_we;
  logic [CW+DW-1:0]  cen_waddr, cen_raddr;
  logic [COORD_W-1:0] cen_rdata;
  assign cen_we    = accept && command == CMD_CENTRE && ci_ok && di_ok;
  assign cen_waddr = {CW'(cluster_index), DW'(dim_index)};
  assign cen_raddr = {k, d};

  ncrc_ram #(.WIDTH(COORD_W), .DEPTH(CDEPTH * DDEPTH)) u_centre (
    .clk(clk), .we(cen_we), .waddr(cen_waddr), .wdata(coordinate),
    .raddr(cen_raddr), .rdata(cen_rdata)
  );

  // example buffer
  logic ex_we;
  logic [COORD_W-1:0] ex_rdata;
  assign ex_we = accept && command == CMD_EXAMPLE && di_ok;
  ncrc_ram #(.WIDTH(COORD_W), .DEPTH(DDEPTH)) u_example (
    .clk(clk), .we(ex_we), .waddr(DW'(dim_index)), .wdata(coordinate),
    .raddr(d), .rdata(ex_rdata)
  );

  // radius and label table
  logic rl_we;
  logic [CW-1:0] best;
  logic [RADIUS_W+LABEL_W-1:0] rl_rdata;
  assign rl_we = accept && command == CMD_RADIUS && ci_ok;
  ncrc_ram #(.WIDTH(RADIUS_W + LABEL_W), .DEPTH(CDEPTH)) u_radius (
    .clk(clk), .we(rl_we), .waddr(CW'(cluster_index)), .wdata({radius_in, label_in}),
    .raddr(best), .rdata(rl_rdata)
  );

  // stages of the scan: RAM read, diff square, accumulate
  logic          p1_v, p1_last_d, p1_first_k;
  logic [CW-1:0] p1_k;
  logic          p2_v, p2_last_d;
  logic [CW-1:0] p2_k;
  logic [33:0]   sq;
  logic signed [16:0] diff;
  logic [16:0]   mag;
  assign diff = $signed({cen_rdata[15], cen_rdata}) - $signed({ex_rdata[15], ex_rdata});
  assign mag  = diff[16] ? 17'(-diff) : 17'(diff);

  logic [SUM_W-1:0] acc, best_sum;
  logic [SUM_W:0]   acc_add;
  logic             p2_first;
  logic             have_best;
  assign acc_add = {1'b0, (p2_first ? '0 : acc)} + (SUM_W + 1)'(sq);

  logic [SUM_W-1:0] sum_done;
  assign sum_done = acc_add[SUM_W] ? SUM_MAX : acc_add[SUM_W-1:0];

  logic [2*RADIUS_W-1:0] rad_sq;
  logic                  covered;
  logic                  root_start, root_done;
  logic [ROOT_W-1:0]     root;
  logic [LABEL_W-1:0]    best_label;

  ncrc_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(root_start), .radicand(best_sum),
    .done(root_done), .root(root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      p1_v       <= 1'b0;
      p2_v       <= 1'b0;
      have_best  <= 1'b0;
      root_start <= 1'b0;
    end else begin
      root_start <= 1'b0;
      // stage 1 follows the read address
      p1_v       <= (state == S_SCAN);
      p1_k       <= k;
      p1_last_d  <= (d == last_d);
      p1_first_k <= (d == '0);
      // stage 2 squares
      p2_v      <= p1_v;
      p2_k      <= p1_k;
      p2_last_d <= p1_last_d;
      p2_first  <= p1_first_k;
      sq        <= 34'(mag) * 34'(mag);
      // stage 3 accumulates and compares; later cluster wins ties
      if (p2_v) begin
        acc <= sum_done;
        if (p2_last_d && (!have_best || sum_done <= best_sum)) begin
          best_sum  <= sum_done;
          best      <= p2_k;
          have_best <= 1'b1;
        end
      end
      if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (ex_we && DW'(dim_index) == last_d) begin
            state     <= S_SCAN;
            k         <= '0;
            d         <= '0;
            have_best <= 1'b0;
          end
        end
        S_SCAN: begin
          if (d == last_d) begin
            d <= '0;
            if (k == last_k) state <= S_DRAIN;
            else k <= k + CW'(1);
          end else begin
            d <= d + DW'(1);
          end
        end
        S_DRAIN: begin
          // wait for the accumulator pipeline to empty
          if (!p1_v && !p2_v) state <= S_RADIUS;
        end
        S_RADIUS: begin
          // radius RAM read of best completes this cycle
          state <= S_COVER;
        end
        S_COVER: begin
          rad_sq     <= rl_rdata[RADIUS_W+LABEL_W-1:LABEL_W] *
                        rl_rdata[RADIUS_W+LABEL_W-1:LABEL_W];
          best_label <= rl_rdata[LABEL_W-1:0];
          root_start <= 1'b1;
          state      <= S_ROOT;
        end
        S_ROOT: begin
          // done is a one-cycle pulse; the root stays put afterwards
          covered <= best_sum <= SUM_W'(rad_sq);
          if (root_done) state <= S_OUT;
        end
        S_OUT: begin
          // hold here while the previous result still waits
          if (!out_valid) begin
            out_valid       <= 1'b1;
            known           <= covered;
            label           <= covered ? best_label : unknown_label;
            nearest_cluster <= 7'(best);
            distance        <= root;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `NCRC_ASSERT_IMP(a_no_accept_busy, state != S_IDLE, !accept,
    "item accepted during search")
  `NCRC_ASSERT_NEXT(a_out_from_done, state == S_OUT && !out_valid, out_valid,
    "result not presented")
  `NCRC_ASSERT_IMP(a_scan_bounds, state == S_SCAN, k <= last_k && d <= last_d,
    "scan counter out of range")
endmodule
`default_nettype wire
